### hw/rtl/ica_pkg.sv
package ica_pkg;

  localparam int START_W = 10;
  localparam int END_W   = 11;
  localparam int SEATS_W = 16;
  localparam int CAP_W   = 16;
  // Loads are kept modulo 2^17.
  localparam int VAL_W   = 17;

  typedef struct packed {
    logic [START_W-1:0] start_station;
    logic [END_W-1:0]   end_station;
    logic [SEATS_W-1:0] seats;
  } ica_req_t;

  typedef struct packed {
    logic accepted;
  } ica_res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WA,
    S_ADD_WB,
    S_REF_CHK,
    S_REF_RA,
    S_REF_WA,
    S_REF_RB,
    S_REF_WB,
    S_ROOT_RD,
    S_ROOT_CHK,
    S_RESULT
  } ica_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load_req;
    logic add_rd;
    logic add_wa;
    logic add_wb;
    logic ref_shift;
    logic ref_rd;
    logic ref_wr;
    logic sel_pb;
    logic root_rd;
    logic start_undo;
    logic set_acc;
    logic acc_val;
    logic load_res;
  } ica_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic req_bad;
    logic a_le_b;
    logic pa_gt1;
    logic pa_ne_pb;
    logic fits;
    logic undo;
    logic res_free;
  } ica_sts_t;

endpackage

### hw/rtl/ica_stream_if.sv
interface ica_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/ica_ctrl.sv
module ica_ctrl
  import ica_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  ica_sts_t sts_i,
  output logic     req_ready_o,
  output ica_cmd_t cmd_o
);

  ica_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          if (sts_i.req_bad) begin
            cmd_o.set_acc = 1'b1;
            cmd_o.acc_val = 1'b0;
            state_d       = S_RESULT;
          end else begin
            state_d = S_ADD_RD;
          end
        end
      end
      S_ADD_RD: begin
        if (sts_i.a_le_b) begin
          cmd_o.add_rd = 1'b1;
          state_d      = S_ADD_WA;
        end else begin
          state_d = S_REF_CHK;
        end
      end
      S_ADD_WA: begin
        cmd_o.add_wa = 1'b1;
        state_d      = S_ADD_WB;
      end
      S_ADD_WB: begin
        cmd_o.add_wb = 1'b1;
        state_d      = S_ADD_RD;
      end
      S_REF_CHK: begin
        if (sts_i.pa_gt1) begin
          cmd_o.ref_shift = 1'b1;
          state_d         = S_REF_RA;
        end else if (sts_i.undo) begin
          cmd_o.set_acc = 1'b1;
          cmd_o.acc_val = 1'b0;
          state_d       = S_RESULT;
        end else begin
          state_d = S_ROOT_RD;
        end
      end
      S_REF_RA: begin
        cmd_o.ref_rd = 1'b1;
        state_d      = S_REF_WA;
      end
      S_REF_WA: begin
        cmd_o.ref_wr = 1'b1;
        state_d      = sts_i.pa_ne_pb ? S_REF_RB : S_REF_CHK;
      end
      S_REF_RB: begin
        cmd_o.ref_rd = 1'b1;
        cmd_o.sel_pb = 1'b1;
        state_d      = S_REF_WB;
      end
      S_REF_WB: begin
        cmd_o.ref_wr = 1'b1;
        cmd_o.sel_pb = 1'b1;
        state_d      = S_REF_CHK;
      end
      S_ROOT_RD: begin
        cmd_o.root_rd = 1'b1;
        state_d       = S_ROOT_CHK;
      end
      S_ROOT_CHK: begin
        if (sts_i.fits) begin
          cmd_o.set_acc = 1'b1;
          cmd_o.acc_val = 1'b1;
          state_d       = S_RESULT;
        end else begin
          cmd_o.start_undo = 1'b1;
          state_d          = S_ADD_RD;
        end
      end
      S_RESULT: begin
        if (sts_i.res_free) begin
          cmd_o.load_res = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

### hw/rtl/ica_dp.sv
module ica_dp
  import ica_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  ica_req_t         req_i,
  input  logic             res_ready_i,
  output logic             res_valid_o,
  output ica_res_t         res_o,
  input  ica_cmd_t         cmd_i,
  output ica_sts_t         sts_o
);

  localparam int LVL    = $clog2(LEAVES);
  localparam int BASE   = 1 << LVL;
  localparam int NODE_W = LVL + 1;
  localparam int DEPTH  = 2 * BASE;
  localparam int IDX_W  = NODE_W + 1;

  logic [VAL_W-1:0] add_mem [DEPTH];
  logic [VAL_W-1:0] max_mem [DEPTH];

  logic [CAP_W-1:0]  cap_q;
  logic [NODE_W-1:0] clr_q;
  logic [IDX_W-1:0]  a_q, b_q;
  logic [NODE_W-1:0] pa_q, pb_q, lo_leaf_q, hi_leaf_q;
  logic [VAL_W-1:0]  v_q;
  logic              undo_q;
  logic              acc_q;
  logic              res_valid_q;
  ica_res_t          res_q;

  logic [VAL_W-1:0]  add_a_q, max_a_q, add_b_q, max_b_q;
  logic [VAL_W-1:0]  tot_a, tot_b;

  logic [NODE_W-1:0] lo_leaf_d, hi_leaf_d, ref_node;
  logic [IDX_W-1:0]  b_dec;

  logic              rd_en;
  logic [NODE_W-1:0] rd_a_addr, rd_b_addr;
  logic              add_we, max_we;
  logic [NODE_W-1:0] add_waddr, max_waddr;
  logic [VAL_W-1:0]  add_wdata, max_wdata;

  assign lo_leaf_d = NODE_W'(32'(req_i.start_station) - 32'd1 + 32'(BASE));
  assign hi_leaf_d = NODE_W'(32'(req_i.end_station) - 32'd2 + 32'(BASE));
  assign ref_node  = cmd_i.sel_pb ? pb_q : pa_q;
  assign tot_a     = add_a_q + max_a_q;
  assign tot_b     = add_b_q + max_b_q;
  assign b_dec     = b_q[0] ? b_q : (b_q - IDX_W'(1));

  // Read and write port selection.
  always_comb begin
    rd_en     = cmd_i.add_rd | cmd_i.ref_rd | cmd_i.root_rd;
    rd_a_addr = a_q[NODE_W-1:0];
    rd_b_addr = b_q[NODE_W-1:0];
    if (cmd_i.ref_rd) begin
      rd_a_addr = {ref_node[NODE_W-2:0], 1'b0};
      rd_b_addr = {ref_node[NODE_W-2:0], 1'b1};
    end else if (cmd_i.root_rd) begin
      rd_a_addr = NODE_W'(1);
    end

    add_we    = 1'b0;
    add_waddr = a_q[NODE_W-1:0];
    add_wdata = add_a_q + v_q;
    max_we    = 1'b0;
    max_waddr = ref_node;
    max_wdata = (tot_a > tot_b) ? tot_a : tot_b;
    if (cmd_i.clr_step) begin
      add_we    = 1'b1;
      max_we    = 1'b1;
      add_waddr = clr_q;
      max_waddr = clr_q;
      add_wdata = '0;
      max_wdata = '0;
    end else if (cmd_i.add_wa) begin
      add_we = a_q[0];
    end else if (cmd_i.add_wb) begin
      add_we    = ~b_q[0];
      add_waddr = b_q[NODE_W-1:0];
      add_wdata = add_b_q + v_q;
    end else if (cmd_i.ref_wr) begin
      max_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_we) begin
      add_mem[add_waddr] <= add_wdata;
    end
    if (max_we) begin
      max_mem[max_waddr] <= max_wdata;
    end
    if (rd_en) begin
      add_a_q <= add_mem[rd_a_addr];
      max_a_q <= max_mem[rd_a_addr];
      add_b_q <= add_mem[rd_b_addr];
      max_b_q <= max_mem[rd_b_addr];
    end
  end

  // Walk registers; payload only, so no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      a_q       <= {1'b0, lo_leaf_d};
      b_q       <= {1'b0, hi_leaf_d};
      pa_q      <= lo_leaf_d;
      pb_q      <= hi_leaf_d;
      lo_leaf_q <= lo_leaf_d;
      hi_leaf_q <= hi_leaf_d;
      v_q       <= {1'b0, req_i.seats};
    end else if (cmd_i.start_undo) begin
      a_q  <= {1'b0, lo_leaf_q};
      b_q  <= {1'b0, hi_leaf_q};
      pa_q <= lo_leaf_q;
      pb_q <= hi_leaf_q;
      v_q  <= -v_q;
    end else if (cmd_i.add_wa) begin
      if (a_q[0]) begin
        a_q <= a_q + IDX_W'(1);
      end
    end else if (cmd_i.add_wb) begin
      a_q <= a_q >> 1;
      b_q <= b_dec >> 1;
    end else if (cmd_i.ref_shift) begin
      pa_q <= pa_q >> 1;
      pb_q <= pb_q >> 1;
    end
    if (cmd_i.set_acc) begin
      acc_q <= cmd_i.acc_val;
    end
    if (cmd_i.load_res) begin
      res_q.accepted <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= '0;
      clr_q       <= '0;
      undo_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + NODE_W'(1);
      end
      if (cmd_i.load_req) begin
        undo_q <= 1'b0;
      end else if (cmd_i.start_undo) begin
        undo_q <= 1'b1;
      end
      if (cmd_i.load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.clr_done = (clr_q == '1);
    sts_o.req_bad  = (req_i.start_station == '0)
                  || (req_i.end_station <= {1'b0, req_i.start_station})
                  || (32'(req_i.end_station) > 32'(LEAVES));
    sts_o.a_le_b   = (a_q <= b_q);
    sts_o.pa_gt1   = (pa_q > NODE_W'(1));
    sts_o.pa_ne_pb = (pa_q != pb_q);
    sts_o.fits     = (tot_a <= {{(VAL_W-CAP_W){1'b0}}, cap_q});
    sts_o.undo     = undo_q;
    sts_o.res_free = ~res_valid_q | res_ready_i;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### hw/rtl/interval_capacity_admission_core.sv
// Channel   Direction  Payload                                 Transaction when
// req_i     in         start_station, end_station, seats       req_i.valid & req_i.ready
// res_o     out        accepted                                res_o.valid & res_o.ready
// cfg       in         cfg_wdata_i (capacity)                  cfg_we_i
//
// One request at a time. A request runs the add walk up the tree level by level, the
// refresh of both boundary paths and the check of the root total; when it is rejected
// the walk and the refresh run again to undo its seats, and a malformed interval goes
// straight to the result. After reset a clearing pass zeroes the tree before the first
// request transaction is taken. A result waits in the output register while the next
// request is taken, so a stalled result side only holds the block at the end of a
// request.
module interval_capacity_admission_core
  import ica_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  ica_stream_if.sink       req_i,
  ica_stream_if.source     res_o
);

  ica_cmd_t cmd;
  ica_sts_t sts;
  logic     req_ready;
  logic     res_valid;
  ica_res_t res_data;

  // The controller sequences the add walk, the refresh of both boundary paths,
  // the check of the root total against capacity and, on rejection, a second
  // add and refresh with the negated seat count.
  ica_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .sts_i       (sts),
    .req_ready_o (req_ready),
    .cmd_o       (cmd)
  );

  // The datapath holds the two node stores, the walk indices, the capacity
  // register and the result register.
  ica_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i.data),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res_data),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign req_i.ready = req_ready;
  assign res_o.valid = res_valid;
  assign res_o.data  = res_data;

endmodule

### bench/ica_admission_scoreboard.sv
`timescale 1ns / 1ps

// Watches the request, result and capacity ports of the admission core, keeps
// its own copy of the per-segment loads and checks every result in order.
module ica_admission_scoreboard
  import ica_pkg::*;
#(
  parameter int          LEAVES       = 1024,
  parameter int unsigned REPORT_LIMIT = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  input  ica_req_t         req_data_i,
  input  logic             res_valid_i,
  input  logic             res_ready_i,
  input  ica_res_t         res_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    ica_req_t req;
    logic     accepted;
  } verdict_t;

  // Load on each segment, one entry per leaf. Committed loads never exceed the
  // capacity in force when they were committed, so a plain sum per segment gives the same maximum as the tree.
  logic [VAL_W-1:0] seg_load [LEAVES];
  logic [CAP_W-1:0] capacity_q;
  verdict_t         expected_verdicts [$];
  verdict_t         oldest;
  int unsigned      mismatches;

  // Decides one reservation and commits its seats when it fits.
  function automatic logic predict_admission(input ica_req_t r);
    int unsigned first_seg;
    int unsigned last_seg;
    int unsigned peak;
    int unsigned load;
    int unsigned i;
    if (r.start_station == '0 || r.end_station <= {1'b0, r.start_station} ||
        32'(r.end_station) > LEAVES) begin
      return 1'b0;
    end
    first_seg = 32'(r.start_station) - 1;
    last_seg  = 32'(r.end_station) - 2;
    peak      = 0;
    for (i = 0; i < LEAVES; i++) begin
      load = 32'(seg_load[i]);
      if (i >= first_seg && i <= last_seg) begin
        load = load + 32'(r.seats);
      end
      if (load > peak) begin
        peak = load;
      end
    end
    if (peak > 32'(capacity_q)) begin
      return 1'b0;
    end
    for (i = first_seg; i <= last_seg; i++) begin
      seg_load[i] = seg_load[i] + VAL_W'(r.seats);
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q = '0;
      for (int i = 0; i < LEAVES; i++) begin
        seg_load[i] = '0;
      end
      expected_verdicts.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        capacity_q = cfg_wdata_i;
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: result transaction with nothing expected, accepted %0b",
                     $realtime, res_data_i.accepted);
          end
        end else begin
          oldest = expected_verdicts.pop_front();
          if (res_data_i.accepted !== oldest.accepted) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: start %0d end %0d seats %0d: accepted expected %0b, got %0b",
                       $realtime, oldest.req.start_station, oldest.req.end_station,
                       oldest.req.seats, oldest.accepted, res_data_i.accepted);
            end
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_verdicts.push_back({req_data_i, predict_admission(req_data_i)});
      end
      pending_o    <= expected_verdicts.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

### bench/tb_interval_capacity_admission_core.sv
`timescale 1ns / 1ps

// Stimulus for the interval capacity admission core. The scoreboard beside the
// block predicts and checks every result; this module only drives the ports
// and gives the verdict.
module tb_interval_capacity_admission_core;
  import ica_pkg::*;

  localparam int          LEAVES      = 1024;
  // Cycles without any transaction before the run is declared hung. The
  // limit is far longer than the clearing pass after reset or a rejected
  // request, so this leaves a wide margin for stalls and gaps.
  localparam int unsigned HANG_LIMIT  = 20000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int          PHASES      = 6;
  localparam int          PHASE_ITEMS = 305;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  int unsigned      sb_fails;
  int unsigned      sb_pending;
  int unsigned      quiet_cycles;
  int unsigned      res_stall_left;
  // When low, neither side starts new gaps or stalls.
  logic             idling_on;

  ica_stream_if #(.payload_t(ica_req_t)) req_if ();
  ica_stream_if #(.payload_t(ica_res_t)) res_if ();

  interval_capacity_admission_core #(
    .LEAVES(LEAVES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  ica_admission_scoreboard #(
    .LEAVES(LEAVES)
  ) u_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_data_i  (req_if.data),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_data_i  (res_if.data),
    .fail_count_o(sb_fails),
    .pending_o   (sb_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(30, 80);
  endfunction

  function automatic ica_req_t make_booking(input int unsigned from_st,
                                            input int unsigned to_st,
                                            input int unsigned seat_cnt);
    ica_req_t r;
    r.start_station = START_W'(from_st);
    r.end_station   = END_W'(to_st);
    r.seats         = SEATS_W'(seat_cnt);
    return r;
  endfunction

  // A random reservation. Most are well formed, with short hops, hops touching
  // either end of the line and long spans; a few are malformed intervals.
  // Seat counts mostly fit within seat_top, with some zero and oversized ones.
  function automatic ica_req_t random_booking(input int unsigned seat_top);
    int unsigned kind;
    int unsigned from_st;
    int unsigned to_st;
    int unsigned seat_cnt;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      case ($urandom_range(0, 2))
        0: begin
          from_st = 0;
          to_st   = $urandom_range(0, 2047);
        end
        1: begin
          from_st = $urandom_range(1, 1023);
          to_st   = $urandom_range(0, from_st);
        end
        default: begin
          from_st = $urandom_range(0, 1023);
          to_st   = $urandom_range(LEAVES + 1, 2047);
        end
      endcase
    end else if (kind < 30) begin
      from_st = $urandom_range(1, LEAVES - 1);
      to_st   = from_st + $urandom_range(1, 4);
      if (to_st > LEAVES) begin
        to_st = LEAVES;
      end
    end else if (kind < 45) begin
      if ($urandom_range(0, 1) == 0) begin
        from_st = 1;
        to_st   = $urandom_range(2, LEAVES);
      end else begin
        from_st = $urandom_range(1, LEAVES - 1);
        to_st   = LEAVES;
      end
    end else begin
      from_st = $urandom_range(1, LEAVES - 1);
      to_st   = $urandom_range(from_st + 1, LEAVES);
    end
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      seat_cnt = 0;
    end else if (kind < 12) begin
      seat_cnt = $urandom_range(0, 65535);
    end else if (kind < 15) begin
      seat_cnt = 65535;
    end else begin
      seat_cnt = $urandom_range(1, seat_top);
    end
    return make_booking(from_st, to_st, seat_cnt);
  endfunction

  // Offers one reservation and returns just after the edge of its transaction.
  // Valid is left high, so the next call either keeps it high or lowers it for
  // a gap; callers that stop sending lower it themselves.
  task automatic send_booking(input ica_req_t r);
    int unsigned gap;
    gap = idling_on ? pick_gap() : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Stops sending and waits until every expected result has been taken. The
  // first edge lets the scoreboard count the transaction just made.
  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb_pending != 0) @(posedge clk_i);
  endtask

  // Only called with the block idle, straight after wait_all_results.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // The result side starts stalls at random while idling is on; a stall already
  // begun runs out, and otherwise it is ready.
  always @(posedge clk_i) begin
    if (res_stall_left != 0) begin
      res_if.ready   <= 1'b0;
      res_stall_left <= res_stall_left - 1;
    end else if (idling_on && $urandom_range(0, 3) == 0) begin
      res_if.ready   <= 1'b0;
      res_stall_left <= pick_gap();
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Watchdog: any transaction on either stream restarts the count.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int unsigned prev_cap;
    int unsigned phase_cap;
    int unsigned seat_top;
    int unsigned phase_caps [PHASES];
    phase_caps = '{1000, 4000, 12000, 30000, 50000, 65535};

    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    req_if.valid   <= 1'b0;
    req_if.data    <= '0;
    idling_on      <= 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Capacity is still at its reset value of zero: any seat is too many, but
    // a zero-seat request fits, and malformed intervals are always turned away.
    send_booking(make_booking(1, 2, 1));
    send_booking(make_booking(1, 2, 0));
    send_booking(make_booking(0, 5, 3));
    send_booking(make_booking(5, 5, 1));
    send_booking(make_booking(10, 3, 1));
    send_booking(make_booking(1, LEAVES + 1, 1));
    send_booking(make_booking(1023, 2047, 0));
    wait_all_results();

    // A small capacity: fill the whole line, then press against the limit on
    // the first, last and a middle segment.
    write_capacity(16'd300);
    send_booking(make_booking(1, LEAVES, 100));
    send_booking(make_booking(LEAVES - 1, LEAVES, 200));
    send_booking(make_booking(1, 2, 201));
    send_booking(make_booking(512, 513, 200));
    send_booking(make_booking(511, 514, 1));
    send_booking(make_booking(1, LEAVES, 0));
    send_booking(make_booking(LEAVES - 1, LEAVES, 1));
    wait_all_results();

    // Capacity lowered below what is already committed: the loads stay and
    // even a zero-seat request is now refused.
    write_capacity(16'd50);
    send_booking(make_booking(2, 3, 0));
    send_booking(make_booking(700, 701, 1));
    wait_all_results();

    // Largest capacity with the largest seat count, which cannot fit on top of
    // the existing load.
    write_capacity(16'hffff);
    send_booking(make_booking(3, 4, 65535));
    wait_all_results();

    // Random phases with rising capacity. Loads only ever grow, so each phase
    // opens fresh headroom and sizes most seat counts to a fraction of it,
    // which keeps a healthy mix of accepted and refused reservations.
    prev_cap = 300;
    for (int phase = 0; phase < PHASES; phase++) begin
      phase_cap = phase_caps[phase];
      seat_top  = (phase_cap - prev_cap) / 8;
      if (seat_top == 0) begin
        seat_top = 1;
      end
      write_capacity(CAP_W'(phase_cap));
      for (int item = 0; item < PHASE_ITEMS; item++) begin
        // Switch between stretches with and without idling now and then.
        if (item % 60 == 0) begin
          idling_on <= ($urandom_range(0, 3) != 0);
        end
        // Halfway through, hold the sender back until the block has drained.
        if (item == PHASE_ITEMS / 2) begin
          wait_all_results();
        end
        send_booking(random_booking(seat_top));
      end
      wait_all_results();
      prev_cap = phase_cap;
    end

    idling_on <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb_fails == 0 && sb_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### interval_capacity_admission_core.f
hw/rtl/ica_pkg.sv
hw/rtl/ica_stream_if.sv
hw/rtl/ica_ctrl.sv
hw/rtl/ica_dp.sv
hw/rtl/interval_capacity_admission_core.sv
bench/ica_admission_scoreboard.sv
bench/tb_interval_capacity_admission_core.sv
